// ----- design/top_k_record_hash_tracker_top_defines.svh -----
// Assertion macros shared by the tracker RTL.
`ifndef TOP_K_RECORD_HASH_TRACKER_TOP_DEFINES_SVH
`define TOP_K_RECORD_HASH_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TKRHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkrht: same-cycle check failed");

// Next-cycle implication.
`define TKRHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkrht: next-cycle check failed");

// Delayed implication.
`define TKRHT_ASSERT_LAT3(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error("tkrht: latency check failed");

`else

`define TKRHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TKRHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`define TKRHT_ASSERT_LAT3(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/tkrht_pkg.sv -----
package tkrht_pkg;

    localparam int CAPACITY = 64;
    localparam int HASH_W   = 64;
    localparam int SZ_W     = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int BRK_W    = $clog2(CAPACITY);
    localparam int CTR_W    = 32;
    localparam int IDX_W    = 2;
    localparam int SIZE_RST = 16;

    localparam logic [IDX_W-1:0] REG_INITIAL_SIZE = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_GROW_ENABLE  = IDX_W'(1);

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REPLACE,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic capture;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // Clamp a programmed size into 1..CAPACITY.
    function automatic logic [CNT_W-1:0] eff_size(input logic [SZ_W-1:0] s);
        int v;
        v = int'(s);
        if (v < 1) v = 1;
        if (v > CAPACITY) v = CAPACITY;
        return CNT_W'(v);
    endfunction

endpackage

// ----- design/top_k_record_hash_tracker_top.sv -----
// Top-k record hash tracker. Raise start with a 64-bit hash while busy is low; the
// word is taken at that clock edge. Every word produces exactly one result, shown on
// o_modified, o_items_seen, o_records_seen and o_target_size for a single cycle
// while o_valid is high; the receiver cannot stall, so capture the result in that cycle.
// Each word is handled in order: the hash is broadcast down the cell row and every
// cell's compare registered, then the sorted row is shifted and the counters
// updated, then the result is presented. busy drops as the result appears, so a
// new word can be taken in the strobe cycle but not before. Configuration writes
// (index 0 initial size, index 1 grow enable) take effect at once; writing the
// initial size empties the store but keeps the counters. Write configuration only
// while busy is low.
`include "top_k_record_hash_tracker_top_defines.svh"

module top_k_record_hash_tracker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tkrht_pkg::HASH_W-1:0]  i_hash_value,
    input  logic                          i_cfg_we,
    input  logic [tkrht_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [tkrht_pkg::SZ_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic                          o_modified,
    output logic [tkrht_pkg::CTR_W-1:0]   o_items_seen,
    output logic [tkrht_pkg::CTR_W-1:0]   o_records_seen,
    output logic [tkrht_pkg::SZ_W-1:0]    o_target_size
);

    tkrht_pkg::t_cell_cmd                w_cmd;
    logic [tkrht_pkg::HASH_W-1:0]        w_hash;
    logic [tkrht_pkg::HASH_W-1:0]        w_cell_hash [tkrht_pkg::CAPACITY];
    logic [tkrht_pkg::CAPACITY-1:0]      w_lt;
    logic [tkrht_pkg::CAPACITY-1:0]      w_eq;
    logic [tkrht_pkg::CAPACITY-1:0]      w_valid;

    // Sequencer, decision logic, size/breaker state and the result registers.
    tkrht_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_hash         (i_hash_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_lt           (w_lt),
        .i_eq           (w_eq),
        .o_cmd          (w_cmd),
        .o_hash         (w_hash),
        .o_valid        (o_valid),
        .o_modified     (o_modified),
        .o_items_seen   (o_items_seen),
        .o_records_seen (o_records_seen),
        .o_target_size  (o_target_size)
    );

    // Sorted row, smallest entry in cell 0. The row ends behave as a left
    // neighbor that is below any hash and a right neighbor that never is.
    for (genvar gi = 0; gi < tkrht_pkg::CAPACITY; gi++) begin : g_cell
        logic [tkrht_pkg::HASH_W-1:0] w_left_hash;
        logic                         w_left_lt;
        logic                         w_left_valid;
        logic [tkrht_pkg::HASH_W-1:0] w_right_hash;
        logic                         w_right_lt;

        if (gi == 0) begin : g_head
            assign w_left_hash  = '0;
            assign w_left_lt    = 1'b1;
            assign w_left_valid = 1'b1;
        end else begin : g_left
            assign w_left_hash  = w_cell_hash[gi-1];
            assign w_left_lt    = w_lt[gi-1];
            assign w_left_valid = w_valid[gi-1];
        end

        if (gi == tkrht_pkg::CAPACITY - 1) begin : g_tail
            assign w_right_hash = '0;
            assign w_right_lt   = 1'b0;
        end else begin : g_right
            assign w_right_hash = w_cell_hash[gi+1];
            assign w_right_lt   = w_lt[gi+1];
        end

        tkrht_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_hash       (w_hash),
            .i_left_hash  (w_left_hash),
            .i_left_lt    (w_left_lt),
            .i_left_valid (w_left_valid),
            .i_right_hash (w_right_hash),
            .i_right_lt   (w_right_lt),
            .o_hash       (w_cell_hash[gi]),
            .o_lt         (w_lt[gi]),
            .o_eq         (w_eq[gi]),
            .o_valid      (w_valid[gi])
        );
    end

    // An accepted word makes the block busy right away.
    `TKRHT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // Every accepted word yields its result strobe.
    `TKRHT_ASSERT_LAT3(a_result_latency, i_clk, i_rst_n, start && !busy, o_valid)
    // The strobe cycle is always free to take the next word.
    `TKRHT_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy)
    // Inserts can never outnumber offered words.
    `TKRHT_ASSERT_IMP(a_records_le_items, i_clk, i_rst_n, o_valid, o_records_seen <= o_items_seen)

endmodule

// ----- design/tkrht_cell.sv -----
module tkrht_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tkrht_pkg::t_cell_cmd          i_cmd,
    input  logic [tkrht_pkg::HASH_W-1:0]  i_hash,
    input  logic [tkrht_pkg::HASH_W-1:0]  i_left_hash,
    input  logic                          i_left_lt,
    input  logic                          i_left_valid,
    input  logic [tkrht_pkg::HASH_W-1:0]  i_right_hash,
    input  logic                          i_right_lt,
    output logic [tkrht_pkg::HASH_W-1:0]  o_hash,
    output logic                          o_lt,
    output logic                          o_eq,
    output logic                          o_valid
);

    logic [tkrht_pkg::HASH_W-1:0] r_hash;
    logic [tkrht_pkg::HASH_W-1:0] n_hash;
    logic                         r_valid;
    logic                         n_valid;
    logic                         r_lt;
    logic                         r_eq;

    // Insert: entries at or above the insert point move up one cell.
    // Replace: entries below the insert point move down, dropping the smallest.
    always_comb begin
        n_hash  = r_hash;
        n_valid = r_valid;
        case (i_cmd.op)
            tkrht_pkg::OP_INSERT: begin
                n_valid = r_valid | i_left_valid;
                if (!r_lt) begin
                    if (i_left_lt) n_hash = i_hash;
                    else           n_hash = i_left_hash;
                end
            end
            tkrht_pkg::OP_REPLACE: begin
                if (r_lt) begin
                    if (i_right_lt) n_hash = i_right_hash;
                    else            n_hash = i_hash;
                end
            end
            tkrht_pkg::OP_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.capture) begin
                r_lt <= r_valid && (r_hash < i_hash);
                r_eq <= r_valid && (r_hash == i_hash);
            end
        end
    end

    assign o_hash  = r_hash;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_valid = r_valid;

endmodule

// ----- design/tkrht_ctrl.sv -----
module tkrht_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [tkrht_pkg::HASH_W-1:0]  i_hash,
    input  logic                          i_cfg_we,
    input  logic [tkrht_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [tkrht_pkg::SZ_W-1:0]    i_cfg_data,
    input  logic [tkrht_pkg::CAPACITY-1:0] i_lt,
    input  logic [tkrht_pkg::CAPACITY-1:0] i_eq,
    output tkrht_pkg::t_cell_cmd          o_cmd,
    output logic [tkrht_pkg::HASH_W-1:0]  o_hash,
    output logic                          o_valid,
    output logic                          o_modified,
    output logic [tkrht_pkg::CTR_W-1:0]   o_items_seen,
    output logic [tkrht_pkg::CTR_W-1:0]   o_records_seen,
    output logic [tkrht_pkg::SZ_W-1:0]    o_target_size
);

    tkrht_pkg::t_state              r_state;
    tkrht_pkg::t_state              n_state;
    logic [tkrht_pkg::HASH_W-1:0]   r_hash;
    logic                           r_grow_en;
    logic                           n_grow_en;
    logic [tkrht_pkg::CNT_W-1:0]    r_count;
    logic [tkrht_pkg::CNT_W-1:0]    n_count;
    logic [tkrht_pkg::CNT_W-1:0]    r_grown;
    logic [tkrht_pkg::CNT_W-1:0]    n_grown;
    logic [tkrht_pkg::BRK_W-1:0]    r_breaker;
    logic [tkrht_pkg::BRK_W-1:0]    n_breaker;
    logic [tkrht_pkg::CTR_W-1:0]    r_items;
    logic [tkrht_pkg::CTR_W-1:0]    n_items;
    logic [tkrht_pkg::CTR_W-1:0]    r_records;
    logic [tkrht_pkg::CTR_W-1:0]    n_records;
    logic                           r_modified;
    logic                           n_modified;
    logic                           r_out_valid;

    logic found;
    logic take_fill;
    logic take_grow;
    logic take_repl;
    logic upd_mod;
    logic cfg_wr_size;
    tkrht_pkg::t_op upd_op;

    assign cfg_wr_size = i_cfg_we && (i_cfg_idx == tkrht_pkg::REG_INITIAL_SIZE);

    // Decide from the compare flags the cells captured in the compare state.
    always_comb begin
        found     = |i_eq;
        take_fill = !found && (r_count < r_grown);
        take_grow = !found && !take_fill && r_grow_en
                    && (r_grown < tkrht_pkg::CNT_W'(tkrht_pkg::CAPACITY))
                    && (tkrht_pkg::CNT_W'(r_breaker) < r_count)
                    && i_lt[r_breaker];
        take_repl = !found && !take_fill && !take_grow
                    && (r_count != '0) && i_lt[0];
        upd_mod   = take_fill || take_grow || take_repl;
        if (take_fill || take_grow) upd_op = tkrht_pkg::OP_INSERT;
        else if (take_repl)         upd_op = tkrht_pkg::OP_REPLACE;
        else                        upd_op = tkrht_pkg::OP_HOLD;
    end

    always_comb begin
        case (r_state)
            tkrht_pkg::ST_IDLE: n_state = i_start ? tkrht_pkg::ST_CMP : tkrht_pkg::ST_IDLE;
            tkrht_pkg::ST_CMP:  n_state = tkrht_pkg::ST_UPD;
            tkrht_pkg::ST_UPD:  n_state = tkrht_pkg::ST_IDLE;
            default:            n_state = tkrht_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.op      = tkrht_pkg::OP_HOLD;
        case (r_state)
            tkrht_pkg::ST_IDLE: begin
                if (cfg_wr_size) o_cmd.op = tkrht_pkg::OP_CLEAR;
            end
            tkrht_pkg::ST_CMP: begin
                o_busy        = 1'b1;
                o_cmd.capture = 1'b1;
            end
            tkrht_pkg::ST_UPD: begin
                o_busy   = 1'b1;
                o_cmd.op = upd_op;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_grow_en  = r_grow_en;
        n_count    = r_count;
        n_grown    = r_grown;
        n_breaker  = r_breaker;
        n_items    = r_items;
        n_records  = r_records;
        n_modified = r_modified;
        if (cfg_wr_size) begin
            n_count   = '0;
            n_breaker = '0;
            n_grown   = tkrht_pkg::eff_size(i_cfg_data);
        end
        if (i_cfg_we && (i_cfg_idx == tkrht_pkg::REG_GROW_ENABLE)) begin
            n_grow_en = i_cfg_data[0];
        end
        if (r_state == tkrht_pkg::ST_UPD) begin
            n_modified = upd_mod;
            if (r_items != '1) n_items = r_items + tkrht_pkg::CTR_W'(1);
            if (upd_mod && (r_records != '1)) n_records = r_records + tkrht_pkg::CTR_W'(1);
            if (take_fill) begin
                n_count = r_count + tkrht_pkg::CNT_W'(1);
                if ((r_count + tkrht_pkg::CNT_W'(1)) == r_grown) n_breaker = '0;
            end else if (take_grow) begin
                n_count   = r_count + tkrht_pkg::CNT_W'(1);
                n_grown   = r_grown + tkrht_pkg::CNT_W'(1);
                n_breaker = r_breaker + tkrht_pkg::BRK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == tkrht_pkg::ST_IDLE) && i_start) r_hash <= i_hash;
        r_modified <= n_modified;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tkrht_pkg::ST_IDLE;
            r_grow_en   <= 1'b1;
            r_count     <= '0;
            r_grown     <= tkrht_pkg::eff_size(tkrht_pkg::SZ_W'(tkrht_pkg::SIZE_RST));
            r_breaker   <= '0;
            r_items     <= '0;
            r_records   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grow_en   <= n_grow_en;
            r_count     <= n_count;
            r_grown     <= n_grown;
            r_breaker   <= n_breaker;
            r_items     <= n_items;
            r_records   <= n_records;
            r_out_valid <= (r_state == tkrht_pkg::ST_UPD);
        end
    end

    assign o_hash         = r_hash;
    assign o_valid        = r_out_valid;
    assign o_modified     = r_modified;
    assign o_items_seen   = r_items;
    assign o_records_seen = r_records;
    assign o_target_size  = tkrht_pkg::SZ_W'(r_grown);

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // Spare register indexes: the block must ignore writes to these.
    localparam logic [tkrht_pkg::IDX_W-1:0] REG_SPARE_A = tkrht_pkg::IDX_W'(2);
    localparam logic [tkrht_pkg::IDX_W-1:0] REG_SPARE_B = tkrht_pkg::IDX_W'(3);

    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;
    localparam int HISTORY_DEPTH = 32;
    localparam int SEGMENTS      = 10;
    localparam int SEGMENT_WORDS = 170;

    // One result word as the block presents it.
    typedef struct {
        logic                          modified;
        logic [tkrht_pkg::CTR_W-1:0]   items;
        logic [tkrht_pkg::CTR_W-1:0]   records;
        logic [tkrht_pkg::SZ_W-1:0]    size;
    } t_tracker_result;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start   = 1'b0;
    logic                          busy;
    logic [tkrht_pkg::HASH_W-1:0]  i_hash_value = '0;
    logic                          i_cfg_we     = 1'b0;
    logic [tkrht_pkg::IDX_W-1:0]   i_cfg_idx    = '0;
    logic [tkrht_pkg::SZ_W-1:0]    i_cfg_data   = '0;
    logic                          o_valid;
    logic                          o_modified;
    logic [tkrht_pkg::CTR_W-1:0]   o_items_seen;
    logic [tkrht_pkg::CTR_W-1:0]   o_records_seen;
    logic [tkrht_pkg::SZ_W-1:0]    o_target_size;

    top_k_record_hash_tracker_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_hash_value   (i_hash_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_modified     (o_modified),
        .o_items_seen   (o_items_seen),
        .o_records_seen (o_records_seen),
        .o_target_size  (o_target_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker shadow: ascending store of the largest distinct hashes,
    // target size, breaker rank and the two saturating counters.
    // ------------------------------------------------------------------
    logic [tkrht_pkg::HASH_W-1:0]  kept_hashes [tkrht_pkg::CAPACITY];
    int                            kept_count;
    int                            target_now;
    int                            breaker_pos;
    logic [tkrht_pkg::CTR_W-1:0]   items_total;
    logic [tkrht_pkg::CTR_W-1:0]   records_total;
    logic [tkrht_pkg::SZ_W-1:0]    size_setting;
    logic                          grow_setting;

    t_tracker_result               pending_results[$];
    logic [tkrht_pkg::HASH_W-1:0]  hash_log[$];
    logic [tkrht_pkg::HASH_W-1:0]  climb_hash;
    int                            mismatch_count = 0;
    int                            cycle_count    = 0;
    bit                            gaps_allowed   = 1'b0;

    // Clamp a programmed size: zero acts as one, anything past the row as the row.
    function automatic int clamp_target(logic [tkrht_pkg::SZ_W-1:0] s);
        int v;
        v = int'(s);
        if (v < 1) v = 1;
        if (v > tkrht_pkg::CAPACITY) v = tkrht_pkg::CAPACITY;
        return v;
    endfunction

    function automatic void empty_store();
        kept_count  = 0;
        breaker_pos = 0;
        target_now  = clamp_target(size_setting);
    endfunction

    function automatic int rank_of(logic [tkrht_pkg::HASH_W-1:0] h);
        int r;
        r = 0;
        for (int i = 0; i < kept_count; i++)
            if (kept_hashes[i] < h) r++;
        return r;
    endfunction

    // Shift the upper part of the row up by one and drop h into its slot.
    function automatic void insert_hash(logic [tkrht_pkg::HASH_W-1:0] h);
        int p;
        p = rank_of(h);
        if (kept_count >= tkrht_pkg::CAPACITY) return;
        for (int i = kept_count; i > p; i--)
            kept_hashes[i] = kept_hashes[i-1];
        kept_hashes[p] = h;
        kept_count++;
    endfunction

    // Evict the minimum; entries below h slide down one slot.
    function automatic void evict_minimum(logic [tkrht_pkg::HASH_W-1:0] h);
        int p;
        p = rank_of(h);
        if (p == 0) return;
        for (int i = 0; i + 1 < p; i++)
            kept_hashes[i] = kept_hashes[i+1];
        kept_hashes[p-1] = h;
    endfunction

    // Advance the shadow by one accepted word and queue the result it causes.
    function automatic void track_hash(logic [tkrht_pkg::HASH_W-1:0] h);
        t_tracker_result r;
        bit hit;
        bit changed;
        hit     = 1'b0;
        changed = 1'b0;
        if (items_total != '1) items_total++;
        for (int i = 0; i < kept_count; i++)
            if (kept_hashes[i] == h) hit = 1'b1;
        if (!hit) begin
            if (kept_count < target_now) begin
                insert_hash(h);
                if (kept_count == target_now) breaker_pos = 0;
                changed = 1'b1;
            end else if (grow_setting && target_now < tkrht_pkg::CAPACITY &&
                         breaker_pos < kept_count && kept_hashes[breaker_pos] < h) begin
                insert_hash(h);
                target_now++;
                breaker_pos++;
                changed = 1'b1;
            end else if (kept_count > 0 && kept_hashes[0] < h) begin
                evict_minimum(h);
                changed = 1'b1;
            end
        end
        if (changed && records_total != '1) records_total++;
        r.modified = changed;
        r.items    = items_total;
        r.records  = records_total;
        r.size     = tkrht_pkg::SZ_W'(target_now);
        pending_results.push_back(r);
    endfunction

    function automatic void apply_register(logic [tkrht_pkg::IDX_W-1:0] idx,
                                           logic [tkrht_pkg::SZ_W-1:0] data);
        if (idx == tkrht_pkg::REG_INITIAL_SIZE) begin
            size_setting = data;
            empty_store();
        end else if (idx == tkrht_pkg::REG_GROW_ENABLE) begin
            grow_setting = data[0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking. Sample mid-cycle, away from the driving edge; the
    // strobe lasts exactly one cycle and cannot be held off.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    always @(negedge i_clk) begin
        t_tracker_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (o_modified !== want.modified)
                    report_mismatch($sformatf("modified %b, want %b",
                                              o_modified, want.modified));
                if (o_items_seen !== want.items)
                    report_mismatch($sformatf("items_seen %0d, want %0d",
                                              o_items_seen, want.items));
                if (o_records_seen !== want.records)
                    report_mismatch($sformatf("records_seen %0d, want %0d",
                                              o_records_seen, want.records));
                if (o_target_size !== want.size)
                    report_mismatch($sformatf("target_size %0d, want %0d",
                                              o_target_size, want.size));
            end
        end else if (i_rst_n && o_valid !== 1'b0) begin
            report_mismatch("result strobe is unknown");
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("top_k_record_hash_tracker_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving. Every task is entered and left right after a rising edge;
    // start is raised by send_hash and lowered only by the gap tasks, so
    // back-to-back words keep it high without a glitch.
    // ------------------------------------------------------------------
    task automatic send_hash(input logic [tkrht_pkg::HASH_W-1:0] h);
        start        <= 1'b1;
        i_hash_value <= h;
        // busy only moves at rising edges, so its mid-cycle value is what
        // the next edge sees
        @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
        track_hash(h);
        hash_log.push_back(h);
        if (hash_log.size() > HISTORY_DEPTH) void'(hash_log.pop_front());
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every pending result word has come, then let the row settle.
    task automatic settle_block();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [tkrht_pkg::IDX_W-1:0] idx,
                                  input logic [tkrht_pkg::SZ_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_register(idx, data);
        @(posedge i_clk);
    endtask

    // Random burst of idle cycles on the sender side, only while gaps are on.
    task automatic maybe_gap();
        if (gaps_allowed && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 7));
    endtask

    // Pick the next random hash: a mix that keeps the row full and churning.
    function automatic logic [tkrht_pkg::HASH_W-1:0] pick_hash();
        int kind;
        logic [tkrht_pkg::HASH_W-1:0] h;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            h = {$urandom, $urandom};
        end else if (kind < 48 && hash_log.size() != 0) begin
            // repeat a recent word: mostly a hit on a kept hash
            h = hash_log[$urandom_range(0, hash_log.size() - 1)];
        end else if (kind < 62) begin
            // tiny values lose against a full row
            h = tkrht_pkg::HASH_W'($urandom_range(0, 255));
        end else if (kind < 84) begin
            // climbing run: each word beats the breaker, so the target grows
            climb_hash = climb_hash + tkrht_pkg::HASH_W'($urandom_range(1, 4096));
            h = climb_hash;
        end else if (kind < 94) begin
            case ($urandom_range(0, 3))
                0:       h = '1;
                1:       h = tkrht_pkg::HASH_W'(1)
                             << $urandom_range(0, tkrht_pkg::HASH_W - 1);
                2:       h = ~(tkrht_pkg::HASH_W'(1)
                               << $urandom_range(0, tkrht_pkg::HASH_W - 1));
                default: h = '0;
            endcase
        end else if (kept_count > 0) begin
            // hover around the minimum: equal, just above, just below
            h = kept_hashes[0] + tkrht_pkg::HASH_W'($urandom_range(0, 2))
                - tkrht_pkg::HASH_W'(1);
        end else begin
            h = {$urandom, $urandom};
        end
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default size after reset: fill from empty, extremes, and a repeated hash.
    task automatic test_default_fill();
        send_hash('0);
        send_hash('1);
        send_hash('1);
        idle_gap(3);
        send_hash(64'h8000_0000_0000_0000);
        send_hash(64'h0000_0000_0000_0001);
    endtask

    // Size zero acts as one, sizes past the row as the full row.
    task automatic test_size_clamp();
        settle_block();
        write_register(tkrht_pkg::REG_INITIAL_SIZE, tkrht_pkg::SZ_W'(0));
        send_hash(64'd100);
        send_hash(64'd50);    // below the only entry: dropped
        send_hash(64'd200);   // beats the breaker: target grows to two
        send_hash(64'd150);   // full, below breaker: replaces the minimum
        settle_block();
        write_register(tkrht_pkg::REG_INITIAL_SIZE, '1);
        send_hash(64'd7);
        send_hash(64'd7);
    endtask

    // With growth off a full row follows only the replace-minimum rule.
    task automatic test_grow_disabled();
        settle_block();
        write_register(tkrht_pkg::REG_INITIAL_SIZE, tkrht_pkg::SZ_W'(2));
        write_register(tkrht_pkg::REG_GROW_ENABLE, tkrht_pkg::SZ_W'(0));
        send_hash(64'd10);
        send_hash(64'd20);
        send_hash(64'd30);
        send_hash(64'd5);
        send_hash(64'd30);
    endtask

    // Writes to spare indexes change nothing.
    task automatic test_spare_index();
        settle_block();
        write_register(REG_SPARE_A, '1);
        write_register(REG_SPARE_B, tkrht_pkg::SZ_W'(0));
        write_register(tkrht_pkg::REG_GROW_ENABLE, tkrht_pkg::SZ_W'(1));
        send_hash(64'd40);
        send_hash(64'd60);
    endtask

    // Random mix over several settings, size extremes among them.
    task automatic test_random_mix();
        logic [tkrht_pkg::SZ_W-1:0] sizes [SEGMENTS];
        logic                       grow;
        sizes = '{tkrht_pkg::SZ_W'(60), tkrht_pkg::SZ_W'(1), tkrht_pkg::SZ_W'(64),
                  tkrht_pkg::SZ_W'(0), tkrht_pkg::SZ_W'(127), tkrht_pkg::SZ_W'(2),
                  tkrht_pkg::SZ_W'(8), tkrht_pkg::SZ_W'(33), tkrht_pkg::SZ_W'(0),
                  tkrht_pkg::SZ_W'(0)};
        sizes[8] = tkrht_pkg::SZ_W'($urandom_range(1, 64));
        sizes[9] = tkrht_pkg::SZ_W'($urandom_range(0, 127));
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle_block();
            if (seg == 3 || seg == 7)      grow = 1'b0;
            else if (seg % 2 == 0)         grow = 1'b1;
            else                           grow = 1'($urandom_range(0, 1));
            write_register(tkrht_pkg::REG_INITIAL_SIZE, sizes[seg]);
            write_register(tkrht_pkg::REG_GROW_ENABLE,
                           {(tkrht_pkg::SZ_W-1)'($urandom_range(0, 63)), grow});
            if ($urandom_range(0, 2) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                               tkrht_pkg::SZ_W'($urandom));
            // start each climbing run high so it outranks most random words
            climb_hash = {2'b11, $urandom, 30'($urandom)};
            for (int n = 0; n < SEGMENT_WORDS; n++) begin
                // toggle idling in stretches; the last setting runs flat out
                if (n % 40 == 0)
                    gaps_allowed = (seg != SEGMENTS - 1) && ($urandom_range(0, 2) != 0);
                // once mid-run, drain everything before the next word
                if (seg == 5 && n == 85)
                    settle_block();
                send_hash(pick_hash());
                maybe_gap();
            end
        end
        gaps_allowed = 1'b0;
    endtask

    initial begin
        size_setting  = tkrht_pkg::SZ_W'(tkrht_pkg::SIZE_RST);
        grow_setting  = 1'b1;
        items_total   = '0;
        records_total = '0;
        climb_hash    = '0;
        empty_store();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_fill();
        test_size_clamp();
        test_grow_disabled();
        test_spare_index();
        test_random_mix();

        settle_block();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d result words never came",
                                      pending_results.size()));
        if (mismatch_count == 0) begin
            $display("top_k_record_hash_tracker_top test passed");
        end else begin
            $display("top_k_record_hash_tracker_top test failed");
        end
        $finish;
    end

endmodule
